FILE: hdl/rsmq_pkg.sv
package rsmq_pkg;

    localparam int DATA_W = 64;
    localparam int COEF_W = 63;
    localparam int ETA_W  = 16;
    localparam int DEG_W  = 11;
    localparam int IDX_W  = 10;
    localparam int ADDR_W = 5;
    localparam int DIV_CNT_W = $clog2(DATA_W + 1);

    localparam logic [1:0] REG_MODE    = 2'd0;
    localparam logic [1:0] REG_MODULUS = 2'd1;
    localparam logic [1:0] REG_ETA     = 2'd2;
    localparam logic [1:0] REG_DEGREE  = 2'd3;

    localparam logic              MODE_UNIFORM = 1'b0;
    localparam logic              MODE_SHORT   = 1'b1;
    localparam logic [COEF_W-1:0] RST_MODULUS  = 63'd8380417;
    localparam logic [ETA_W-1:0]  RST_ETA      = 16'd2;
    localparam logic [DEG_W-1:0]  RST_DEGREE   = 11'd256;

    typedef struct packed {
        logic              mode;
        logic [COEF_W-1:0] modulus;
        logic [ETA_W-1:0]  eta;
        logic [DEG_W-1:0]  degree;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] rem;
    } t_div_stat;

endpackage

FILE: hdl/rsmq_div.sv
module rsmq_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rsmq_pkg::t_div_req  i_req,
    output rsmq_pkg::t_div_stat o_stat
);
    import rsmq_pkg::*;

    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic [DATA_W-1:0]    r_rem;
    logic [DATA_W-1:0]    r_dvd;
    logic [DATA_W-1:0]    r_dvs;
    logic [DATA_W-1:0]    w_trial;
    logic                 w_ge;

    // one quotient bit per cycle, remainder only
    always_comb begin
        w_trial = {r_rem[DATA_W-2:0], r_dvd[DATA_W-1]};
        w_ge    = (w_trial >= r_dvs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= DIV_CNT_W'(DATA_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? (w_trial - r_dvs) : w_trial;
            r_dvd <= {r_dvd[DATA_W-2:0], 1'b0};
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.rem  = r_rem;

endmodule

FILE: hdl/rsmq_cfg.sv
module rsmq_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rsmq_pkg::ADDR_W-1:0] paddr,
    input  logic [rsmq_pkg::DATA_W-1:0] pwdata,
    output logic [rsmq_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output rsmq_pkg::t_cfg              o_cfg,
    output logic                        o_wr
);
    import rsmq_pkg::*;

    t_cfg       r_cfg;
    logic [1:0] w_idx;

    assign w_idx  = paddr[ADDR_W-1:ADDR_W-2];
    assign pready = 1'b1;
    assign o_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode    <= MODE_UNIFORM;
            r_cfg.modulus <= RST_MODULUS;
            r_cfg.eta     <= RST_ETA;
            r_cfg.degree  <= RST_DEGREE;
        end else if (o_wr) begin
            case (w_idx)
                REG_MODE:    r_cfg.mode    <= pwdata[0];
                REG_MODULUS: r_cfg.modulus <= pwdata[COEF_W-1:0];
                REG_ETA:     r_cfg.eta     <= pwdata[ETA_W-1:0];
                REG_DEGREE:  r_cfg.degree  <= pwdata[DEG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_MODE:    prdata = {{(DATA_W-1){1'b0}}, r_cfg.mode};
            REG_MODULUS: prdata = {{(DATA_W-COEF_W){1'b0}}, r_cfg.modulus};
            REG_ETA:     prdata = {{(DATA_W-ETA_W){1'b0}}, r_cfg.eta};
            REG_DEGREE:  prdata = {{(DATA_W-DEG_W){1'b0}}, r_cfg.degree};
            default:     prdata = '0;
        endcase
    end

endmodule

FILE: hdl/rejection_sampler_mod_q.sv
// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_stall    i_random_word
// output    out        o_out_valid / i_out_stall  o_coefficient, o_coeff_index, o_last_coeff
// config    in/out     psel penable pwrite pready paddr, pwdata, prdata
//
// a rejected word is dropped without a division; an accepted word runs one division in uniform mode
// and two in short mode, the input stalled until its result is loaded into the output register,
// all on the shared 64-step remainder unit
// after reset and after every register write the rejection limit is rebuilt on that
// unit, the input stalled from reset, or from the access cycle of a write, until the rebuild is done
// a finished word waits in the output register while the next word is taken
module rejection_sampler_mod_q #(
    parameter int MAX_DEGREE = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [rsmq_pkg::DATA_W-1:0] i_random_word,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [rsmq_pkg::COEF_W-1:0] o_coefficient,
    output logic [rsmq_pkg::IDX_W-1:0]  o_coeff_index,
    output logic                        o_last_coeff,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rsmq_pkg::ADDR_W-1:0] paddr,
    input  logic [rsmq_pkg::DATA_W-1:0] pwdata,
    output logic [rsmq_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import rsmq_pkg::*;

    localparam int          DEGX_W = 17;
    localparam logic [DEGX_W-1:0] MAX_DEG = DEGX_W'(MAX_DEGREE);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LIM  = 3'd1;
    localparam logic [2:0] S_DIV1 = 3'd2;
    localparam logic [2:0] S_DIV2 = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    t_cfg      w_cfg;
    logic      w_wr;
    t_div_req  w_req;
    t_div_stat w_stat;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic              r_dirty;
    logic              n_dirty;
    logic              r_neg;
    logic              n_neg;
    logic [DATA_W-1:0] r_limit;
    logic [DEG_W-1:0]  r_count;
    logic              r_out_valid;
    logic [COEF_W-1:0] r_coef;
    logic [IDX_W-1:0]  r_index;
    logic              r_last;

    logic [DATA_W-1:0] w_effq;
    logic [DATA_W-1:0] w_range;
    logic [DATA_W-1:0] w_eta64;
    logic              w_ge_eta;
    logic [DATA_W-1:0] w_dist;
    logic [DATA_W-1:0] w_coef64;
    logic              w_in_acc;
    logic              w_take;
    logic              w_out_free;
    logic              w_load;
    logic [DEGX_W-1:0] w_deg;
    logic [DEGX_W-1:0] w_effdeg;
    logic              w_last;

    rsmq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg),
        .o_wr    (w_wr)
    );

    rsmq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_stat  (w_stat)
    );

    always_comb begin
        w_effq   = (w_cfg.modulus == '0) ? DATA_W'(1) : {1'b0, w_cfg.modulus};
        w_range  = (w_cfg.mode == MODE_SHORT) ?
                   {{(DATA_W-ETA_W-1){1'b0}}, w_cfg.eta, 1'b1} : w_effq;
        w_eta64  = {{(DATA_W-ETA_W){1'b0}}, w_cfg.eta};
        w_ge_eta = (w_stat.rem >= w_eta64);
        w_dist   = w_ge_eta ? (w_stat.rem - w_eta64) : (w_eta64 - w_stat.rem);
        w_coef64 = (r_neg && (w_stat.rem != '0)) ? (w_effq - w_stat.rem) : w_stat.rem;

        o_in_stall = !((r_state == S_IDLE) && !r_dirty && !w_wr);
        w_in_acc   = i_in_valid && !o_in_stall;
        w_take     = w_in_acc && (i_random_word < r_limit);
        w_out_free = !r_out_valid || !i_out_stall;
        w_load     = (r_state == S_OUT) && w_out_free;

        w_deg    = {{(DEGX_W-DEG_W){1'b0}}, w_cfg.degree};
        w_effdeg = (w_deg == '0) ? DEGX_W'(1) : ((w_deg > MAX_DEG) ? MAX_DEG : w_deg);
        w_last   = ({{(DEGX_W-DEG_W){1'b0}}, r_count} + DEGX_W'(1)) >= w_effdeg;
    end

    // sequencer and divider requests
    always_comb begin
        n_state        = r_state;
        n_neg          = r_neg;
        n_dirty        = r_dirty;
        w_req.start    = 1'b0;
        w_req.dividend = i_random_word;
        w_req.divisor  = w_range;
        case (r_state)
            S_IDLE: begin
                if (r_dirty) begin
                    w_req.start    = 1'b1;
                    w_req.dividend = '1;
                    n_dirty        = 1'b0;
                    n_state        = S_LIM;
                end else if (w_take) begin
                    w_req.start = 1'b1;
                    n_state     = S_DIV1;
                end
            end
            S_LIM: begin
                if (w_stat.done) begin
                    n_state = S_IDLE;
                end
            end
            S_DIV1: begin
                if (w_stat.done) begin
                    if (w_cfg.mode == MODE_SHORT) begin
                        w_req.start    = 1'b1;
                        w_req.dividend = w_dist;
                        w_req.divisor  = w_effq;
                        n_neg          = !w_ge_eta;
                        n_state        = S_DIV2;
                    end else begin
                        n_neg   = 1'b0;
                        n_state = S_OUT;
                    end
                end
            end
            S_DIV2: begin
                if (w_stat.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_wr) begin
            n_dirty = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dirty     <= 1'b1;
            r_neg       <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dirty <= n_dirty;
            r_neg   <= n_neg;
            if (w_load) begin
                r_count     <= w_last ? '0 : (r_count + 1'b1);
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_LIM) && w_stat.done) begin
            r_limit <= '1 - w_stat.rem;
        end
        if (w_load) begin
            r_coef  <= w_coef64[COEF_W-1:0];
            r_index <= r_count[IDX_W-1:0];
            r_last  <= w_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_coefficient = r_coef;
    assign o_coeff_index = r_index;
    assign o_last_coeff  = r_last;

endmodule

FILE: hdl/rsmq_chk.sv
module rsmq_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [rsmq_pkg::COEF_W-1:0] o_coefficient,
    input logic [rsmq_pkg::IDX_W-1:0]  o_coeff_index,
    input logic                        o_last_coeff,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_coefficient)
        && $stable(o_coeff_index) && $stable(o_last_coeff))
        else $error("stalled output word changed");

    // no input word taken during a register write
    a_cfg_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite |-> o_in_stall)
        else $error("input taken during register write");

    // limit rebuild after reset keeps the input stalled
    a_rst_stall: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> o_in_stall)
        else $error("input open right after reset");

    // a result never follows its word in the next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !$rose(o_out_valid))
        else $error("result appeared too early");

endmodule

bind rejection_sampler_mod_q rsmq_chk u_rsmq_chk (.*);

FILE: tb/tb_rejection_sampler_mod_q.sv
`timescale 1ns / 100ps

module tb_rejection_sampler_mod_q;
    import rsmq_pkg::*;

    localparam int          MAX_DEG      = 1024;
    localparam int          DRAIN_CYCLES = 300;
    localparam int          REBUILD_WAIT = 100;
    localparam int          HOLD_CYCLES  = 400;
    localparam logic [63:0] ALL_ONES     = {64{1'b1}};
    localparam int          IN_IDLE[4]   = '{0, 69, 0, 11};
    localparam int          OUT_STALL[4] = '{0, 0, 69, 11};

    typedef struct {
        logic [COEF_W-1:0] coefficient;
        logic [IDX_W-1:0]  index;
        logic              last;
    } t_coef_word;

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              i_in_valid    = 1'b0;
    logic              o_in_stall;
    logic [DATA_W-1:0] i_random_word = '0;
    logic              o_out_valid;
    logic              i_out_stall   = 1'b0;
    logic [COEF_W-1:0] o_coefficient;
    logic [IDX_W-1:0]  o_coeff_index;
    logic              o_last_coeff;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [ADDR_W-1:0] paddr         = '0;
    logic [DATA_W-1:0] pwdata        = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // predictor state
    logic              cfg_mode;
    logic [COEF_W-1:0] cfg_modulus;
    logic [ETA_W-1:0]  cfg_eta;
    logic [DEG_W-1:0]  cfg_degree;
    logic [63:0]       word_limit;
    int                coef_count;
    int                coef_total;
    t_coef_word        coef_q[$];

    int   fail_count    = 0;
    int   in_idle_pct   = 0;
    int   out_stall_pct = 0;
    logic hold_req      = 1'b0;
    int   hold_left     = 0;

    rejection_sampler_mod_q #(
        .MAX_DEGREE(MAX_DEG)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_random_word (i_random_word),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_coefficient (o_coefficient),
        .o_coeff_index (o_coeff_index),
        .o_last_coeff  (o_last_coeff),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // long receiver hold-off, counted in cycles
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= hold_req || (hold_left != 0) || ($urandom_range(0, 99) < out_stall_pct);
    end

    always @(posedge i_clk) begin : check_words
        t_coef_word exp_w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (coef_q.size() == 0) begin
                $error("unexpected word: coefficient %0d index %0d last %0d",
                       o_coefficient, o_coeff_index, o_last_coeff);
                fail_count++;
            end else begin
                exp_w = coef_q.pop_front();
                if (o_coefficient !== exp_w.coefficient) begin
                    $error("coefficient mismatch: expected %0d, got %0d",
                           exp_w.coefficient, o_coefficient);
                    fail_count++;
                end
                if (o_coeff_index !== exp_w.index) begin
                    $error("coeff_index mismatch: expected %0d, got %0d",
                           exp_w.index, o_coeff_index);
                    fail_count++;
                end
                if (o_last_coeff !== exp_w.last) begin
                    $error("last_coeff mismatch: expected %0d, got %0d",
                           exp_w.last, o_last_coeff);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic [63:0] eff_modulus();
        return (cfg_modulus == '0) ? 64'd1 : {1'b0, cfg_modulus};
    endfunction

    function automatic logic [63:0] short_span();
        return 64'd2 * 64'(cfg_eta) + 64'd1;
    endfunction

    function automatic void rebuild_limit();
        logic [63:0] r;
        r = (cfg_mode == MODE_SHORT) ? short_span() : eff_modulus();
        word_limit = ALL_ONES - (ALL_ONES % r);
    endfunction

    function automatic void reset_predictor();
        cfg_mode    = MODE_UNIFORM;
        cfg_modulus = RST_MODULUS;
        cfg_eta     = RST_ETA;
        cfg_degree  = RST_DEGREE;
        coef_count  = 0;
        coef_total  = 0;
        rebuild_limit();
    endfunction

    function automatic void predict_coefficient(input logic [63:0] w);
        t_coef_word  e;
        logic [63:0] q;
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] c;
        logic [63:0] eta64;
        int          d;
        if (w >= word_limit) return;
        q     = eff_modulus();
        eta64 = 64'(cfg_eta);
        if (cfg_mode == MODE_SHORT) begin
            v = w % short_span();
            if (v >= eta64) begin
                c = (v - eta64) % q;
            end else begin
                r = (eta64 - v) % q;
                c = (r == 64'd0) ? 64'd0 : q - r;
            end
        end else begin
            c = w % q;
        end
        if (cfg_degree == '0) begin
            d = 1;
        end else if (int'(cfg_degree) > MAX_DEG) begin
            d = MAX_DEG;
        end else begin
            d = int'(cfg_degree);
        end
        e.coefficient = c[COEF_W-1:0];
        e.index       = coef_count[IDX_W-1:0];
        e.last        = (coef_count + 1) >= d;
        coef_count    = e.last ? 0 : coef_count + 1;
        coef_total++;
        coef_q.push_back(e);
    endfunction

    function automatic logic [63:0] pick_word();
        logic [63:0] w;
        case ($urandom_range(0, 9))
            6: w = word_limit - 64'd3 + 64'($urandom_range(0, 6));
            7: w = ALL_ONES - 64'($urandom_range(0, 1000));
            8: w = 64'($urandom_range(0, 300));
            9: w = {16'hFFFF, 16'($urandom), $urandom};
            default: w = {$urandom, $urandom};
        endcase
        return w;
    endfunction

    function automatic logic [COEF_W-1:0] pick_modulus();
        logic [63:0] t;
        t = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: return COEF_W'($urandom_range(2, 20));
            1: return COEF_W'($urandom_range(2, 1 << 23));
            2: return RST_MODULUS;
            3: return 63'h4000_0000_0000_0001;
            4: return 63'd1 << $urandom_range(1, 62);
            5: return t[COEF_W-1:0];
            6: return {COEF_W{1'b1}};
            default: return '0;
        endcase
    endfunction

    function automatic logic [ETA_W-1:0] pick_eta();
        case ($urandom_range(0, 5))
            4: return ETA_W'($urandom);
            5: return {ETA_W{1'b1}};
            default: return ETA_W'($urandom_range(0, 5));
        endcase
    endfunction

    // random junk in the unused upper bits of a register write, when noisy is set
    function automatic logic [63:0] with_junk(input logic [63:0] val, input logic [63:0] mask,
                                              input bit noisy);
        return noisy ? (({$urandom, $urandom} & ~mask) | val) : val;
    endfunction

    task automatic send_word(input logic [63:0] w);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_random_word <= w;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        predict_coefficient(w);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (coef_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        logic [63:0] exp_rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready) break;
        end
        case (idx)
            REG_MODE: begin
                cfg_mode = val[0];
                exp_rd   = 64'(cfg_mode);
            end
            REG_MODULUS: begin
                cfg_modulus = val[COEF_W-1:0];
                exp_rd      = 64'(cfg_modulus);
            end
            REG_ETA: begin
                cfg_eta = val[ETA_W-1:0];
                exp_rd  = 64'(cfg_eta);
            end
            REG_DEGREE: begin
                cfg_degree = val[DEG_W-1:0];
                exp_rd     = 64'(cfg_degree);
            end
            default: exp_rd = '0;
        endcase
        rebuild_limit();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        // read the register back
        psel <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== exp_rd) begin
            $error("prdata mismatch: expected %0h, got %0h", exp_rd, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        // limit rebuild runs after each write
        repeat (REBUILD_WAIT) @(posedge i_clk);
    endtask

    task automatic apply_cfg(input logic mode, input logic [COEF_W-1:0] q,
                             input logic [ETA_W-1:0] eta, input logic [DEG_W-1:0] deg,
                             input bit noisy);
        wait_idle();
        write_reg(REG_MODE, with_junk(64'(mode), 64'h1, noisy));
        write_reg(REG_MODULUS, with_junk(64'(q), 64'h7FFF_FFFF_FFFF_FFFF, noisy));
        write_reg(REG_ETA, with_junk(64'(eta), 64'hFFFF, noisy));
        write_reg(REG_DEGREE, with_junk(64'(deg), 64'h7FF, noisy));
    endtask

    task automatic run_phase(input int n_words, input int idle_sel);
        in_idle_pct   = IN_IDLE[idle_sel];
        out_stall_pct = OUT_STALL[idle_sel];
        repeat (n_words) send_word(pick_word());
    endtask

    task automatic test_reset_values();
        send_word(64'd0);
        send_word(word_limit - 64'd1);
        send_word(ALL_ONES);
        send_word(word_limit);
    endtask

    task automatic test_uniform_extremes();
        // modulus zero acts as one
        apply_cfg(MODE_UNIFORM, '0, RST_ETA, RST_DEGREE, 1'b0);
        send_word(64'h0123_4567_89AB_CDEF);
        apply_cfg(MODE_UNIFORM, {COEF_W{1'b1}}, RST_ETA, RST_DEGREE, 1'b0);
        send_word(ALL_ONES - 64'd1);
        send_word(ALL_ONES - 64'd2);
        // power-of-two range
        apply_cfg(MODE_UNIFORM, 63'h1_0000_0000, RST_ETA, RST_DEGREE, 1'b0);
        send_word(word_limit);
        send_word(word_limit - 64'd1);
    endtask

    task automatic test_short_range();
        int k;
        apply_cfg(MODE_SHORT, RST_MODULUS, 16'd2, RST_DEGREE, 1'b0);
        for (k = 0; k < 5; k++) send_word(64'(k));
        apply_cfg(MODE_SHORT, RST_MODULUS, 16'd0, RST_DEGREE, 1'b0);
        send_word({$urandom, $urandom});
        // eta above the modulus
        apply_cfg(MODE_SHORT, 63'd3, 16'hFFFF, RST_DEGREE, 1'b0);
        send_word(64'd0);
        send_word(64'd65534);
        send_word(64'd131070);
    endtask

    task automatic test_degree_handling();
        apply_cfg(MODE_UNIFORM, 63'd17, RST_ETA, 11'd0, 1'b0);
        send_word(64'd5);
        send_word(64'd40);
        apply_cfg(MODE_UNIFORM, 63'd17, RST_ETA, 11'h7FF, 1'b0);
        send_word(64'd9);
        apply_cfg(MODE_UNIFORM, 63'd17, RST_ETA, 11'd8, 1'b0);
        repeat (3) send_word(64'($urandom_range(0, 1000)));
        // lower degree below the running count
        wait_idle();
        write_reg(REG_DEGREE, 64'd3);
        send_word(64'd1);
        send_word(64'd2);
    endtask

    task automatic test_output_hold_off();
        apply_cfg(MODE_UNIFORM, RST_MODULUS, RST_ETA, 11'd16, 1'b0);
        in_idle_pct   = 0;
        out_stall_pct = 0;
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        repeat (10) send_word({$urandom, $urandom});
        // sender waits for every word to drain
        wait_idle();
        in_idle_pct = IN_IDLE[1];
        repeat (5) send_word({$urandom, $urandom});
    endtask

    task automatic test_random_long_polynomials();
        int long_start;
        int phase;
        long_start = coef_total;
        phase      = 0;
        while (coef_total - long_start < MAX_DEG + 8) begin
            apply_cfg(($urandom_range(0, 2) == 0) ? MODE_SHORT : MODE_UNIFORM,
                      pick_modulus(), pick_eta(),
                      (phase % 2 == 0) ? 11'h7FF : 11'd1024, bit'($urandom_range(0, 1)));
            run_phase(50, phase % 4);
            phase++;
        end
    endtask

    task automatic test_random_short_polynomials();
        int ph;
        for (ph = 0; ph < 4; ph++) begin
            apply_cfg(($urandom_range(0, 1) == 0) ? MODE_SHORT : MODE_UNIFORM,
                      pick_modulus(), pick_eta(),
                      ($urandom_range(0, 4) == 0) ? 11'd0 : DEG_W'($urandom_range(1, 12)),
                      bit'($urandom_range(0, 1)));
            run_phase(25, ph);
        end
    endtask

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        reset_predictor();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_values();
        test_uniform_extremes();
        test_short_range();
        test_degree_handling();
        test_output_hold_off();
        test_random_long_polynomials();
        test_random_short_polynomials();
        wait_idle();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
